// ----- hdl/ifd_pkg.sv -----
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types for the inertial sensor frame decoder: framer phases, frame
// kinds and the decoded frame handed from the framer to the scaler.
// ----------------------------------------------------------------------------
package ifd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  localparam int unsigned WordW  = 16;
  localparam int unsigned AxisW  = 19;
  localparam int unsigned TempW  = 12;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WordW-1:0]  word_x;
    logic signed [WordW-1:0]  word_y;
    logic signed [WordW-1:0]  word_z;
    logic signed [WordW-1:0]  word_t;
  } frame_t;

endpackage

// ----- hdl/imu_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// imu_frame_decoder_unit
// Streaming decoder for sum-checked inertial sensor frames: one received
// byte per word in, one scaled measurement word out per good frame.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_stall  rx_byte
//  output    out_valid/ out_stall frame_kind, axis_x/y/z, temp_tenths
//
//  one byte per cycle while in_stall is low; the framer updates its phase in the accepting cycle
//  a good checksum byte loads the frame register; the frame then passes the
//  scaling multipliers into the output register
//  rst clears phase, counters and valid flags; payload is not cleared
//  in_stall rises only while a frame and a result are both held and the
//  output is stalled
// ----------------------------------------------------------------------------
module imu_frame_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          frame_kind,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_x,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_y,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_z,
  output logic signed [ifd_pkg::TempW-1:0]    temp_tenths
);

  logic            frame_valid;
  logic            frame_take;
  ifd_pkg::frame_t frame;

  ifd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_take  (frame_take),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  ifd_scaler u_scaler (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_kind  (frame_kind),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .axis_z      (axis_z),
    .temp_tenths (temp_tenths)
  );

endmodule

// ----- hdl/ifd_framer.sv -----
// ----------------------------------------------------------------------------
// ifd_framer
// Byte-serial frame hunter: finds header and type, collects the payload,
// checks the sum and registers each good frame for the scaler.
// ----------------------------------------------------------------------------
module ifd_framer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     rx_byte,
  input  logic           frame_take,
  output logic           frame_valid,
  output ifd_pkg::frame_t frame
);

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [3:0] BodyLen   = 4'd8;

  ifd_pkg::phase_t phase;
  ifd_pkg::phase_t phase_next;
  ifd_pkg::kind_t  held_kind;
  logic [3:0]      byte_count;
  logic [7:0]      running_sum;
  logic [7:0]      payload_bytes [8];

  logic accept;
  logic is_hdr;
  logic is_type;
  logic start_frame;
  logic take_byte;
  logic end_frame;
  logic emit;

  assign in_stall = frame_valid & ~frame_take;
  assign accept   = in_valid & ~in_stall;
  assign is_hdr   = (rx_byte == HdrByte);
  assign is_type  = (rx_byte == TypeAccel) || (rx_byte == TypeRate) ||
                    (rx_byte == TypeAngle);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        ifd_pkg::PH_TYPE: begin
          if (is_type) begin
            phase_next = ifd_pkg::PH_BODY;
          end else if (is_hdr) begin
            phase_next = ifd_pkg::PH_TYPE;
          end else begin
            phase_next = ifd_pkg::PH_HUNT;
          end
        end
        ifd_pkg::PH_BODY: begin
          if (byte_count == BodyLen) begin
            phase_next = ifd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_next = is_hdr ? ifd_pkg::PH_TYPE : ifd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // datapath controls
  always_comb begin
    start_frame = 1'b0;
    take_byte   = 1'b0;
    end_frame   = 1'b0;
    if (accept) begin
      unique case (phase)
        ifd_pkg::PH_TYPE: begin
          start_frame = is_type;
        end
        ifd_pkg::PH_BODY: begin
          take_byte = (byte_count != BodyLen);
          end_frame = (byte_count == BodyLen);
        end
        default: begin
          start_frame = 1'b0;
        end
      endcase
    end
    emit = end_frame && (rx_byte == running_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ifd_pkg::PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      held_kind   <= ifd_pkg::KIND_ACCEL;
      frame_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (start_frame) begin
        byte_count  <= '0;
        running_sum <= HdrByte + rx_byte;
        held_kind   <= ifd_pkg::kind_t'(rx_byte[1:0] - 2'd1);
      end else if (take_byte) begin
        byte_count  <= byte_count + 4'd1;
        running_sum <= running_sum + rx_byte;
      end else if (end_frame) begin
        byte_count <= '0;
      end
      if (emit) begin
        frame_valid <= 1'b1;
      end else if (frame_take) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // payload shift line, first byte ends up in entry 0
  always_ff @(posedge clk) begin
    if (take_byte) begin
      for (int i = 0; i < 7; i++) begin
        payload_bytes[i] <= payload_bytes[i+1];
      end
      payload_bytes[7] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame.kind   <= held_kind;
      frame.word_x <= {payload_bytes[1], payload_bytes[0]};
      frame.word_y <= {payload_bytes[3], payload_bytes[2]};
      frame.word_z <= {payload_bytes[5], payload_bytes[4]};
      frame.word_t <= {payload_bytes[7], payload_bytes[6]};
    end
  end

endmodule

// ----- hdl/ifd_scaler.sv -----
// ----------------------------------------------------------------------------
// ifd_scaler
// Scales a decoded frame to hundredths and tenths and holds the result
// word in the output register.
// ----------------------------------------------------------------------------
module ifd_scaler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_valid,
  input  ifd_pkg::frame_t                     frame,
  output logic                                frame_take,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          frame_kind,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_x,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_y,
  output logic signed [ifd_pkg::AxisW-1:0]    axis_z,
  output logic signed [ifd_pkg::TempW-1:0]    temp_tenths
);

  localparam logic [17:0] MulAccel = 18'd15680;
  localparam logic [17:0] MulRate  = 18'd200000;
  localparam logic [17:0] MulAngle = 18'd18000;
  // reciprocal of 34, exact for magnitudes below 2**20
  localparam logic [15:0] RecipDiv = 16'd61681;
  localparam logic [17:0] TempBias = 18'd12325;

  logic [17:0] mul;
  logic signed [ifd_pkg::AxisW-1:0] scaled_x;
  logic signed [ifd_pkg::AxisW-1:0] scaled_y;
  logic signed [ifd_pkg::AxisW-1:0] scaled_z;
  logic [17:0] temp_sum;
  logic [17:0] temp_mag_full;
  logic [31:0] temp_prod;
  logic [11:0] temp_quot;
  logic [11:0] temp_scaled;
  logic        out_ready;

  function automatic logic signed [18:0] scale_axis(logic signed [15:0] raw,
                                                    logic [17:0] m);
    logic signed [34:0] prod;
    logic signed [34:0] bias;
    logic signed [34:0] sum;
    prod = $signed({{19{raw[15]}}, raw}) * $signed({17'd0, m});
    bias = prod[34] ? 35'sd32767 : 35'sd0;
    sum  = prod + bias;
    return sum[33:15];
  endfunction

  always_comb begin
    unique case (frame.kind)
      ifd_pkg::KIND_ACCEL: mul = MulAccel;
      ifd_pkg::KIND_RATE:  mul = MulRate;
      ifd_pkg::KIND_ANGLE: mul = MulAngle;
      default:             mul = MulAngle;
    endcase
  end

  assign scaled_x = scale_axis(frame.word_x, mul);
  assign scaled_y = scale_axis(frame.word_y, mul);
  assign scaled_z = scale_axis(frame.word_z, mul);

  // temperature: trunc((raw + bias) / 34) on the magnitude, sign restored
  always_comb begin
    temp_sum      = {{2{frame.word_t[15]}}, frame.word_t} + TempBias;
    temp_mag_full = temp_sum[17] ? (18'd0 - temp_sum) : temp_sum;
    temp_prod     = temp_mag_full[15:0] * RecipDiv;
    temp_quot     = {1'b0, temp_prod[31:21]};
    temp_scaled   = temp_sum[17] ? (12'd0 - temp_quot) : temp_quot;
  end

  assign out_ready  = ~out_valid | ~out_stall;
  assign frame_take = frame_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frame_kind  <= frame.kind;
      axis_x      <= scaled_x;
      axis_y      <= scaled_y;
      axis_z      <= scaled_z;
      temp_tenths <= $signed(temp_scaled);
    end
  end

endmodule

// ----- hdl/ifd_checker.sv -----
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ifd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [7:0]                       rx_byte,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       frame_kind,
  input logic signed [ifd_pkg::AxisW-1:0] axis_x,
  input logic signed [ifd_pkg::AxisW-1:0] axis_y,
  input logic signed [ifd_pkg::AxisW-1:0] axis_z,
  input logic signed [ifd_pkg::TempW-1:0] temp_tenths
);

  // held result word stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind) &&
      $stable(axis_x) && $stable(axis_y) && $stable(axis_z) && $stable(temp_tenths))
    else $error("result changed while stalled");

  // input only backs up when the output is full and stalled
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a fresh result follows an accepted checksum byte
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding byte");

  // kind and temperature stay inside their defined ranges
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind != 2'd3 && temp_tenths >= -12'sd602 &&
      temp_tenths <= 12'sd1326)
    else $error("result field out of range");

endmodule

bind imu_frame_decoder_unit ifd_checker u_ifd_checker (.*);
